// File: rtl/core/rwbb_pkg.sv
// rwbb_pkg: shared types and constants for the rms waveform bar builder
// no dependencies
`default_nettype none
package rwbb_pkg;
   localparam int unsigned MS_W   = 31;
   localparam int unsigned ACC_W  = 51;
   localparam int unsigned CNT_W  = 20;
   localparam int unsigned AMP_W  = 17;
   localparam int unsigned HGT_W  = 4;
   localparam int unsigned CSR_W  = 20;
   localparam int unsigned IDX_W  = 1;
   localparam logic [IDX_W-1:0] CSR_BAR_COUNT       = 1'b0;
   localparam logic [IDX_W-1:0] CSR_SAMPLES_PER_BAR = 1'b1;
   localparam logic [AMP_W-1:0] AMP_ONE = 17'h10000;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_ACC   = 8'b0000_0010,
      ST_DIV   = 8'b0000_0100,
      ST_CLOSE = 8'b0000_1000,
      ST_RD    = 8'b0001_0000,
      ST_QDIV  = 8'b0010_0000,
      ST_SQRT  = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;
endpackage
`default_nettype wire

// File: rtl/core/rms_waveform_bar_builder.sv
// rms_waveform_bar_builder: per-bar rms envelope, peak normalized
// depends on rwbb_pkg
`default_nettype none
// One sample word is taken per start pulse while busy is low. A sample that
// does not close a bar is accepted in the idle state and accumulated in the
// accumulate state. One that closes a bar adds a bit-serial division of the
// bar's square sum by its sample count and a write of the mean square into
// the bar memory. On the final sample, each of the bars is read back from the
// memory, divided by the maximum (a load and 64 restoring steps) and
// square-rooted (the last 17 of its steps giving one result bit each), then
// shown on the rsp_ ports for one cycle with rsp_valid; a zero maximum gives
// zero amplitudes. The receiver cannot stall, so results are just strobed.
// busy stays high until the last bar is out.
module rms_waveform_bar_builder #(
   parameter int unsigned MAX_BARS    = 64,
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [15:0]                req_sample,
   input  wire logic                              req_final_sample,
   output logic                                   rsp_valid,
   output logic [rwbb_pkg::AMP_W-1:0]             rsp_amplitude,
   output logic [rwbb_pkg::HGT_W-1:0]             rsp_bar_height,
   output logic                                   rsp_last_bar,
   input  wire logic                              csr_write,
   input  wire logic [rwbb_pkg::IDX_W-1:0]        csr_index,
   input  wire logic [rwbb_pkg::CSR_W-1:0]        csr_data
);
   localparam int unsigned AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
   localparam int unsigned SQ_SHIFT = (SAMPLE_BITS > 16) ? 2*(SAMPLE_BITS-16) : 0;
   localparam int unsigned MSW = rwbb_pkg::MS_W;
   localparam int unsigned ACW = rwbb_pkg::ACC_W;

   // configuration
   logic [6:0]  bar_count_ff;
   logic [19:0] spb_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         bar_count_ff <= 7'd32;
         spb_ff       <= 20'd1;
      end else if (csr_write) begin
         case (csr_index)
            rwbb_pkg::CSR_BAR_COUNT:       bar_count_ff <= csr_data[6:0];
            rwbb_pkg::CSR_SAMPLES_PER_BAR: spb_ff <= csr_data;
            default: ;
         endcase
      end
   end
   logic [7:0]  bars;
   logic [19:0] blen;
   always_comb begin
      bars = {1'b0, bar_count_ff};
      if (bars == 8'd0) bars = 8'd1;
      if (bars > 8'(MAX_BARS)) bars = 8'(MAX_BARS);
      blen = (spb_ff == 20'd0) ? 20'd1 : spb_ff;
   end

   // bar mean-square memory
   logic [MSW-1:0] mem [MAX_BARS];
   logic           mem_we;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   logic [MSW-1:0] mem_wdata, mem_rdata_ff;
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_raddr];
   end

   rwbb_pkg::state_type state_ff, state_in;
   logic [ACW-1:0]  acc_ff, acc_in;
   logic [19:0]     cnt_ff, cnt_in;
   logic [7:0]      bidx_ff, bidx_in;
   logic [MSW-1:0]  max_ff, max_in;
   logic            fin_ff, fin_in;
   logic [31:0]     sq_ff, sq_in;
   // shared restoring divider: dividend/quotient shift register, remainder, divisor
   logic [63:0]     dvd_ff, dvd_in;
   logic [32:0]     rem_ff, rem_in;
   logic [31:0]     dsr_ff, dsr_in;
   logic [6:0]      step_ff, step_in;
   // sqrt
   logic [63:0]     sx_ff, sx_in;
   logic [33:0]     sr_ff, sr_in;
   logic [16:0]     root_ff, root_in;
   // output loop
   logic [7:0]      oidx_ff, oidx_in;
   logic            rv_ff, rv_in;
   logic [16:0]     ramp_ff, ramp_in;
   logic [3:0]      rh_ff, rh_in;
   logic            rl_ff, rl_in;

   logic [SAMPLE_BITS-1:0] raw;
   logic [SAMPLE_BITS:0]   mag;
   logic [2*SAMPLE_BITS+1:0] sqf;
   logic [33:0] rtrial;
   logic [33:0] strial;
   logic [33:0] sr_sh;
   logic [20:0] h_full;
   logic [MSW-1:0] ms_sel;

   always_comb begin
      raw = SAMPLE_BITS'($unsigned({{(SAMPLE_BITS > 16 ? SAMPLE_BITS-16 : 0){req_sample[15]}},
                                    req_sample}));
      mag = raw[SAMPLE_BITS-1] ? ((SAMPLE_BITS+1)'(1) << SAMPLE_BITS) - {1'b0, raw}
                               : {1'b0, raw};
      sqf = (2*SAMPLE_BITS+2)'(mag * mag) >> SQ_SHIFT;
   end

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff; cnt_in = cnt_ff; bidx_in = bidx_ff; max_in = max_ff;
      fin_in = fin_ff; sq_in = sq_ff;
      dvd_in = dvd_ff; rem_in = rem_ff; dsr_in = dsr_ff; step_in = step_ff;
      sx_in = sx_ff; sr_in = sr_ff; root_in = root_ff;
      oidx_in = oidx_ff; rv_in = 1'b0; ramp_in = ramp_ff; rh_in = rh_ff; rl_in = rl_ff;
      mem_we = 1'b0; mem_waddr = bidx_ff[AW-1:0]; mem_wdata = dvd_ff[MSW-1:0];
      mem_raddr = oidx_ff[AW-1:0];
      rtrial = {rem_ff, dvd_ff[63]} - {2'b0, dsr_ff};
      sr_sh  = {sr_ff[31:0], sx_ff[63:62]};
      strial = sr_sh - {15'b0, root_ff, 2'b01};
      h_full = ({4'b0, ramp_ff} * 21'd10 + 21'd32768) >> 16;
      ms_sel = (oidx_ff < bidx_ff) ? mem_rdata_ff : '0;
      case (state_ff)
         rwbb_pkg::ST_IDLE: begin
            if (start) begin
               sq_in = 32'(sqf);
               fin_in = req_final_sample;
               state_in = rwbb_pkg::ST_ACC;
            end
         end
         rwbb_pkg::ST_ACC: begin
            if (bidx_ff < bars) begin
               acc_in = acc_ff + ACW'(sq_ff);
               cnt_in = cnt_ff + 20'd1;
               if (cnt_ff + 20'd1 >= blen) begin
                  dvd_in = {13'b0, acc_ff + ACW'(sq_ff)};
                  dsr_in = {12'b0, cnt_ff + 20'd1};
                  rem_in = '0; step_in = '0;
                  state_in = rwbb_pkg::ST_DIV;
               end else if (fin_ff) begin
                  dvd_in = {13'b0, acc_ff + ACW'(sq_ff)};
                  dsr_in = {12'b0, cnt_ff + 20'd1};
                  rem_in = '0; step_in = '0;
                  state_in = rwbb_pkg::ST_DIV;
               end else state_in = rwbb_pkg::ST_IDLE;
            end else if (fin_ff) begin
               oidx_in = '0; state_in = rwbb_pkg::ST_RD;
            end else state_in = rwbb_pkg::ST_IDLE;
         end
         rwbb_pkg::ST_DIV: begin
            // one quotient bit per cycle over 64-bit dividend (low 51 used)
            if (rtrial[33]) rem_in = {rem_ff[31:0], dvd_ff[63]};
            else            rem_in = rtrial[32:0];
            dvd_in = {dvd_ff[62:0], ~rtrial[33]};
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd63) state_in = rwbb_pkg::ST_CLOSE;
         end
         rwbb_pkg::ST_CLOSE: begin
            mem_we = (bidx_ff < 8'(MAX_BARS));
            if (dvd_ff[MSW-1:0] > max_ff) max_in = dvd_ff[MSW-1:0];
            bidx_in = bidx_ff + 8'd1;
            acc_in = '0; cnt_in = '0;
            if (fin_ff) begin
               oidx_in = '0; state_in = rwbb_pkg::ST_RD;
            end else state_in = rwbb_pkg::ST_IDLE;
         end
         rwbb_pkg::ST_RD: begin
            // read issued with oidx; data lands next cycle
            state_in = rwbb_pkg::ST_QDIV;
            step_in = '0;
            dvd_in = '0; rem_in = '0;
         end
         rwbb_pkg::ST_QDIV: begin
            if (step_ff == 7'd0) begin
               dvd_in = {1'b0, ms_sel, 32'b0};
               dsr_in = {1'b0, max_ff};
               rem_in = '0;
               step_in = 7'd1;
               if (max_ff == '0) begin
                  ramp_in = '0; state_in = rwbb_pkg::ST_EMIT;
               end
            end else begin
               if (rtrial[33]) rem_in = {rem_ff[31:0], dvd_ff[63]};
               else            rem_in = rtrial[32:0];
               dvd_in = {dvd_ff[62:0], ~rtrial[33]};
               step_in = step_ff + 7'd1;
               if (step_ff == 7'd64) begin
                  sx_in = {dvd_ff[62:0], ~rtrial[33]};
                  sr_in = '0; root_in = '0; step_in = '0;
                  state_in = rwbb_pkg::ST_SQRT;
               end
            end
         end
         rwbb_pkg::ST_SQRT: begin
            // quotient < 2^33, root needs 17 bits: skip top 15 pairs
            if (step_ff < 7'd15) begin
               sx_in = {sx_ff[61:0], 2'b00};
               step_in = step_ff + 7'd1;
            end else begin
               sx_in = {sx_ff[61:0], 2'b00};
               if (strial[33]) begin
                  sr_in = sr_sh; root_in = {root_ff[15:0], 1'b0};
               end else begin
                  sr_in = strial; root_in = {root_ff[15:0], 1'b1};
               end
               step_in = step_ff + 7'd1;
               if (step_ff == 7'd31) begin
                  ramp_in = strial[33] ? {root_ff[15:0], 1'b0} : {root_ff[15:0], 1'b1};
                  state_in = rwbb_pkg::ST_EMIT;
               end
            end
         end
         rwbb_pkg::ST_EMIT: begin
            rv_in = 1'b1;
            rh_in = (h_full == 21'd0) ? 4'd1 : h_full[3:0];
            rl_in = (oidx_ff + 8'd1 == bars);
            oidx_in = oidx_ff + 8'd1;
            if (oidx_ff + 8'd1 == bars) begin
               acc_in = '0; cnt_in = '0; bidx_in = '0; max_in = '0;
               state_in = rwbb_pkg::ST_IDLE;
            end else state_in = rwbb_pkg::ST_RD;
         end
         default: state_in = rwbb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rwbb_pkg::ST_IDLE;
         acc_ff <= '0; cnt_ff <= '0; bidx_ff <= '0; max_ff <= '0;
         rv_ff <= 1'b0; oidx_ff <= '0;
      end else begin
         state_ff <= state_in;
         acc_ff <= acc_in; cnt_ff <= cnt_in; bidx_ff <= bidx_in; max_ff <= max_in;
         rv_ff <= rv_in; oidx_ff <= oidx_in;
      end
   end
   always_ff @(posedge clock) begin
      fin_ff <= fin_in; sq_ff <= sq_in;
      dvd_ff <= dvd_in; rem_ff <= rem_in; dsr_ff <= dsr_in; step_ff <= step_in;
      sx_ff <= sx_in; sr_ff <= sr_in; root_ff <= root_in;
      ramp_ff <= ramp_in; rh_ff <= rh_in; rl_ff <= rl_in;
   end

   assign busy          = (state_ff != rwbb_pkg::ST_IDLE);
   assign rsp_valid     = rv_ff;
   assign rsp_amplitude = (ramp_ff > rwbb_pkg::AMP_ONE) ? rwbb_pkg::AMP_ONE : ramp_ff;
   assign rsp_bar_height = rh_ff;
   assign rsp_last_bar  = rl_ff;

   // checks
   a_resp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without work");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_bar |-> !busy) else $error("busy after last bar");
   a_height: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bar_height != 4'd0) else $error("zero height");
endmodule
`default_nettype wire

// File: dv/rms_waveform_bar_builder_tb.sv
// rms_waveform_bar_builder_tb: self-checking bench for the rms waveform bar builder
// depends on rwbb_pkg and rms_waveform_bar_builder
module rms_waveform_bar_builder_tb;

   localparam int unsigned BAR_MAX = 64;
   localparam int unsigned STALL_LIMIT = 20000;
   localparam int unsigned SETTLE_CYCLES = 200;

   typedef struct {
      logic signed [15:0] sample;
      logic               is_last;
   } sample_word_type;

   typedef struct {
      logic [rwbb_pkg::AMP_W-1:0] amplitude;
      logic [rwbb_pkg::HGT_W-1:0] height;
      logic                       last_bar;
   } bar_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_sample = '0;
   logic req_final_sample = 1'b0;
   logic rsp_valid;
   logic [rwbb_pkg::AMP_W-1:0] rsp_amplitude;
   logic [rwbb_pkg::HGT_W-1:0] rsp_bar_height;
   logic rsp_last_bar;
   logic csr_write = 1'b0;
   logic [rwbb_pkg::IDX_W-1:0] csr_index = rwbb_pkg::CSR_BAR_COUNT;
   logic [rwbb_pkg::CSR_W-1:0] csr_data = '0;

   rms_waveform_bar_builder u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample(req_sample), .req_final_sample(req_final_sample),
      .rsp_valid(rsp_valid), .rsp_amplitude(rsp_amplitude),
      .rsp_bar_height(rsp_bar_height), .rsp_last_bar(rsp_last_bar),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // pending sample words and bars still owed by the block
   sample_word_type sample_q[$];
   bar_word_type    bar_q[$];
   int unsigned  fail_count = 0;
   int unsigned  stall_cycles = 0;
   bit           idle_enable = 1'b1;
   int unsigned  gap_left = 0;

   // shadow of the envelope state
   logic [30:0] ms_mem[BAR_MAX];
   logic [50:0] sq_sum;
   logic [19:0] sample_cnt;
   logic [6:0]  bar_idx;
   logic [30:0] peak_ms;
   logic [6:0]  cfg_bars;
   logic [19:0] cfg_len;

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic logic [31:0] isqrt64(input logic [63:0] x);
      logic [63:0] root;
      logic [63:0] b;
      root = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= root + b) begin
            x = x - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root[31:0];
   endfunction

   function automatic int unsigned bars_in_use();
      if (cfg_bars == 0) return 1;
      if (cfg_bars > BAR_MAX) return BAR_MAX;
      return cfg_bars;
   endfunction

   function automatic void close_bar();
      logic [30:0] ms;
      ms = (sample_cnt != 0) ? 31'(sq_sum / sample_cnt) : '0;
      if (bar_idx < BAR_MAX) ms_mem[bar_idx] = ms;
      if (ms > peak_ms) peak_ms = ms;
      bar_idx++;
      sq_sum = '0;
      sample_cnt = '0;
   endfunction

   // accumulate one sample; on the last sample queue every bar of the clip
   function automatic void predict_bars(input sample_word_type w);
      logic [16:0] mag;
      logic [31:0] sq;
      int unsigned nbars;
      logic [30:0] ms;
      logic [63:0] ratio;
      logic [31:0] amp;
      logic [35:0] hgt;
      bar_word_type exp_bar;
      nbars = bars_in_use();
      mag = w.sample[15] ? 17'(-$signed({w.sample[15], w.sample})) : 17'(w.sample);
      sq = mag * mag;
      if (bar_idx < nbars) begin
         sq_sum += sq;
         sample_cnt++;
         if (sample_cnt >= ((cfg_len == 0) ? 20'd1 : cfg_len)) close_bar();
      end
      if (!w.is_last) return;
      if (sample_cnt != 0 && bar_idx < nbars) close_bar();
      for (int i = 0; i < nbars; i++) begin
         ms = (i < bar_idx) ? ms_mem[i] : '0;
         amp = 0;
         if (peak_ms != 0) begin
            ratio = ({33'd0, ms} << 32) / peak_ms;
            amp = isqrt64(ratio);
            if (amp > 65536) amp = 65536;
         end
         hgt = (36'(amp) * 10 + 32768) >> 16;
         if (hgt < 1) hgt = 1;
         exp_bar.amplitude = amp[rwbb_pkg::AMP_W-1:0];
         exp_bar.height = hgt[rwbb_pkg::HGT_W-1:0];
         exp_bar.last_bar = (i + 1 == nbars);
         bar_q.insert(bar_q.size(), exp_bar);
      end
      sq_sum = '0;
      sample_cnt = '0;
      bar_idx = '0;
      peak_ms = '0;
   endfunction

   // driver: hold the word until accepted, then maybe idle for a burst
   always @(posedge clock) begin
      sample_word_type w;
      if (!reset) begin
         if (start && !busy) begin
            w.sample = req_sample;
            w.is_last = req_final_sample;
            predict_bars(w);
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (sample_q.size() > 0) begin
               w = sample_q.pop_front();
               req_sample <= w.sample;
               req_final_sample <= w.is_last;
               start <= 1'b1;
               if (idle_enable && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 15);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobed bar word must match the oldest owed bar
   always @(posedge clock) begin
      bar_word_type exp_bar;
      if (!reset && rsp_valid) begin
         if (bar_q.size() == 0) begin
            report("bar word with nothing owed");
         end else begin
            exp_bar = bar_q.pop_front();
            if (rsp_amplitude !== exp_bar.amplitude)
               report($sformatf("amplitude %0d, want %0d", rsp_amplitude, exp_bar.amplitude));
            if (rsp_bar_height !== exp_bar.height)
               report($sformatf("bar height %0d, want %0d", rsp_bar_height, exp_bar.height));
            if (rsp_last_bar !== exp_bar.last_bar)
               report($sformatf("last bar %0b, want %0b", rsp_last_bar, exp_bar.last_bar));
         end
      end
   end

   // watchdog: cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("rms_waveform_bar_builder test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic csr_wr(input logic [rwbb_pkg::IDX_W-1:0] idx,
                         input logic [rwbb_pkg::CSR_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      if (idx == rwbb_pkg::CSR_BAR_COUNT) cfg_bars = value[6:0];
      else cfg_len = value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic push_word(input logic signed [15:0] s, input logic is_last);
      sample_word_type w;
      w.sample = s;
      w.is_last = is_last;
      sample_q.insert(sample_q.size(), w);
   endtask

   // sender holds off until every owed bar is out, then lets the block settle
   task automatic drain();
      while (sample_q.size() != 0 || start || bar_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(0, 15)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int unsigned clip_len;
      sq_sum = '0;
      sample_cnt = '0;
      bar_idx = '0;
      peak_ms = '0;
      cfg_bars = 7'd32;
      cfg_len = 20'd1;
      foreach (ms_mem[i]) ms_mem[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // full-scale extremes, silent bar, tiny bar, partial last bar
      csr_wr(rwbb_pkg::CSR_BAR_COUNT, 20'd4);
      csr_wr(rwbb_pkg::CSR_SAMPLES_PER_BAR, 20'd2);
      push_word(16'sh7FFF, 0); push_word(16'sh8000, 0);
      push_word(0, 0); push_word(0, 0);
      push_word(1, 0); push_word(-1, 0);
      push_word(100, 1);
      drain();

      // all silence with unreached bars: every height is one
      csr_wr(rwbb_pkg::CSR_BAR_COUNT, 20'd3);
      csr_wr(rwbb_pkg::CSR_SAMPLES_PER_BAR, 20'd1);
      push_word(0, 1);
      drain();

      // extra samples past the last bar are ignored
      csr_wr(rwbb_pkg::CSR_BAR_COUNT, 20'd2);
      push_word(-300, 0); push_word(200, 0); push_word(16'sh7FFF, 0);
      push_word(16'sh8000, 0); push_word(5, 1);
      drain();

      // zero bar count and zero bar length act as one
      csr_wr(rwbb_pkg::CSR_BAR_COUNT, 20'd0);
      csr_wr(rwbb_pkg::CSR_SAMPLES_PER_BAR, 20'd0);
      push_word(16'sh5555, 0); push_word(-16'sh2AAA, 1);
      drain();

      // bar count saturates, longest bar length closes only on the last sample
      csr_wr(rwbb_pkg::CSR_BAR_COUNT, 20'hFFFFF);
      csr_wr(rwbb_pkg::CSR_SAMPLES_PER_BAR, 20'hFFFFF);
      push_word(16'sh1234, 0); push_word(-16'sh4321, 0); push_word(16'sh7FFF, 1);
      drain();

      // random clips, mostly well formed with short bars
      for (int n = 0; n < 100;) begin
         if (n > 75) idle_enable = 1'b0;
         case ($urandom_range(0, 7))
            0: csr_wr(rwbb_pkg::CSR_BAR_COUNT, 20'd64);
            1: csr_wr(rwbb_pkg::CSR_BAR_COUNT, 20'd1);
            default: csr_wr(rwbb_pkg::CSR_BAR_COUNT, 20'($urandom_range(1, 12)));
         endcase
         csr_wr(rwbb_pkg::CSR_SAMPLES_PER_BAR, 20'($urandom_range(1, 4)));
         clip_len = $urandom_range(1, 24);
         for (int k = 0; k < clip_len; k++)
            push_word(rand_sample(), k == clip_len - 1);
         n += clip_len;
         drain();
      end

      if (fail_count == 0) begin
         $display("rms_waveform_bar_builder test passed");
      end else begin
         $display("rms_waveform_bar_builder test failed");
      end
      $finish;
   end
endmodule
